### rtl/core/three_channel_peak_level_check_core_defines.svh
// Assertion macros for the three-channel peak level check core.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef THREE_CHANNEL_PEAK_LEVEL_CHECK_CORE_DEFINES_SVH
`define THREE_CHANNEL_PEAK_LEVEL_CHECK_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define TCPLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define TCPLC_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define TCPLC_ASSERT(lbl, prop, msg)
`define TCPLC_NEVER(lbl, expr, msg)
`endif
`endif

### rtl/core/tcplc_pkg.sv
// Shared types and constants of the three-channel peak level check core.
// No dependencies; used by the lane, merge and top-level modules.
`timescale 1ns / 1ps
package tcplc_pkg;

  // Width of one channel sample and of a positive peak.
  localparam int unsigned SampleW = 16;
  localparam int unsigned PeakW   = 15;
  localparam int unsigned MismW   = 16;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_SKIP_FRAMES   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_FRAMES = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LEVEL     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEVEL     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_MISMATCH  = 3'd4;

  // Reset values of the level registers.
  localparam logic [PeakW-1:0] MIN_LEVEL_RST    = 15'd5000;
  localparam logic [PeakW-1:0] MAX_LEVEL_RST    = 15'd31000;
  localparam logic [MismW-1:0] MAX_MISMATCH_RST = 16'd1000;

  // Verdict codes.
  typedef enum logic [2:0] {
    VERDICT_PASS      = 3'd0,
    VERDICT_QUIET     = 3'd1,
    VERDICT_CLIP      = 3'd2,
    VERDICT_MISMATCH  = 3'd3,
    VERDICT_TOO_SHORT = 3'd4
  } verdict_e;

  // Level status of one channel's captured peak.
  typedef struct packed {
    logic below_min;
    logic above_max;
  } lane_flags_t;

endpackage

### rtl/core/three_channel_peak_level_check_core.sv
// Top level of the three-channel peak level check core.
// Depends on tcplc_pkg, tcplc_lane, tcplc_merge and the defines header.
//
// Usage: each input transaction carries one frame (three signed 16-bit
// samples plus an end-of-recording flag) on in_valid_i / in_stall_o.
// Frames are counted per recording; after skip_frames frames, the positive
// peak of each channel is tracked over window_frames frames by three
// parallel lanes. The frame that completes the window produces one result
// transaction (verdict and the three peaks) on out_valid_o / out_stall_i;
// a recording that ends earlier produces a too-short result instead.
// Frames that complete nothing produce no result.
// Throughput is one frame per cycle while in_stall_o is low. A result is
// registered twice: the capture stage takes the lane peaks at the edge that
// accepts its frame, and the output register, fed by the merging stage,
// loads from the capture stage once it is free.
// When the receiver stalls, the output register holds its result and the
// capture stage can still take one more result. Once a result waits in the
// capture stage behind the held output register, in_stall_o is raised for
// every frame until the output register is free again.
// Reset clears the frame count, peaks and pipeline, and loads the default
// registers. The user must write registers through cfg_we_i only while idle; the block does not enforce this.
`timescale 1ns / 1ps
`include "three_channel_peak_level_check_core_defines.svh"
module three_channel_peak_level_check_core #(
  parameter int unsigned FRAME_COUNT_BITS = 20,
  localparam int unsigned CfgDataW = (FRAME_COUNT_BITS > 16) ? FRAME_COUNT_BITS : 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write port
  input  logic                                  cfg_we_i,
  input  logic [tcplc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]                   cfg_data_i,
  // Frame channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [tcplc_pkg::SampleW-1:0]  sample_a_i,
  input  logic signed [tcplc_pkg::SampleW-1:0]  sample_b_i,
  input  logic signed [tcplc_pkg::SampleW-1:0]  sample_c_i,
  input  logic                                  end_of_recording_i,
  // Result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [2:0]                            verdict_o,
  output logic [tcplc_pkg::PeakW-1:0]           peak_a_o,
  output logic [tcplc_pkg::PeakW-1:0]           peak_b_o,
  output logic [tcplc_pkg::PeakW-1:0]           peak_c_o
);

  localparam int unsigned IdxW = FRAME_COUNT_BITS + 1;
  localparam logic [FRAME_COUNT_BITS-1:0] FrameRst = FRAME_COUNT_BITS'(16000);

  // Configuration registers
  logic [FRAME_COUNT_BITS-1:0]    skip_q;
  logic [FRAME_COUNT_BITS-1:0]    window_q;
  logic [tcplc_pkg::PeakW-1:0]    min_level_q;
  logic [tcplc_pkg::PeakW-1:0]    max_level_q;
  logic [tcplc_pkg::MismW-1:0]    max_mismatch_q;

  // Recording state
  logic [IdxW-1:0]                frame_idx_q;
  logic [IdxW-1:0]                frame_idx_d;
  logic                           given_q;
  logic                           given_d;

  // Pipeline control
  logic                           cap_valid_q;
  logic                           cap_valid_d;
  logic                           cap_short_q;
  logic                           out_valid_q;
  logic                           out_valid_d;
  logic                           out_load;
  logic                           in_acc;
  logic                           cap_load;

  logic [FRAME_COUNT_BITS-1:0]    win;
  logic [IdxW-1:0]                stop;
  logic [IdxW-1:0]                stop_m1;
  logic                           in_window;
  logic                           emit_win;
  logic                           emit_short;

  logic [tcplc_pkg::PeakW-1:0]    snap_a;
  logic [tcplc_pkg::PeakW-1:0]    snap_b;
  logic [tcplc_pkg::PeakW-1:0]    snap_c;
  tcplc_pkg::lane_flags_t         flags_a;
  tcplc_pkg::lane_flags_t         flags_b;
  tcplc_pkg::lane_flags_t         flags_c;
  tcplc_pkg::verdict_e            verdict;

  tcplc_pkg::verdict_e            verdict_q;
  logic [tcplc_pkg::PeakW-1:0]    peak_a_q;
  logic [tcplc_pkg::PeakW-1:0]    peak_b_q;
  logic [tcplc_pkg::PeakW-1:0]    peak_c_q;

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q         <= FrameRst;
      window_q       <= FrameRst;
      min_level_q    <= tcplc_pkg::MIN_LEVEL_RST;
      max_level_q    <= tcplc_pkg::MAX_LEVEL_RST;
      max_mismatch_q <= tcplc_pkg::MAX_MISMATCH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tcplc_pkg::CFG_SKIP_FRAMES:   skip_q         <= cfg_data_i[FRAME_COUNT_BITS-1:0];
        tcplc_pkg::CFG_WINDOW_FRAMES: window_q       <= cfg_data_i[FRAME_COUNT_BITS-1:0];
        tcplc_pkg::CFG_MIN_LEVEL:     min_level_q    <= cfg_data_i[tcplc_pkg::PeakW-1:0];
        tcplc_pkg::CFG_MAX_LEVEL:     max_level_q    <= cfg_data_i[tcplc_pkg::PeakW-1:0];
        tcplc_pkg::CFG_MAX_MISMATCH:  max_mismatch_q <= cfg_data_i[tcplc_pkg::MismW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Window bounds; an empty window counts as one frame.
  assign win       = (window_q == '0) ? FRAME_COUNT_BITS'(1) : window_q;
  assign stop      = {1'b0, skip_q} + {1'b0, win};
  assign stop_m1   = stop - IdxW'(1);
  assign in_window = (frame_idx_q >= {1'b0, skip_q}) && (frame_idx_q < stop);
  assign emit_win  = !given_q && (frame_idx_q >= stop_m1);
  assign emit_short = end_of_recording_i && !given_q && !emit_win;

  // Handshake and pipeline advance.
  assign out_load    = cap_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = cap_valid_q && !out_load;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cap_load    = in_acc && (emit_win || emit_short);
  assign cap_valid_d = cap_load || (cap_valid_q && !out_load);
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // Frame count and verdict flag of the current recording.
  always_comb begin
    frame_idx_d = frame_idx_q;
    given_d     = given_q;
    if (in_acc) begin
      if (end_of_recording_i) begin
        frame_idx_d = '0;
        given_d     = 1'b0;
      end else begin
        if (frame_idx_q != {IdxW{1'b1}}) begin
          frame_idx_d = frame_idx_q + IdxW'(1);
        end
        if (emit_win) begin
          given_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_idx_q <= '0;
      given_q     <= 1'b0;
      cap_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      frame_idx_q <= frame_idx_d;
      given_q     <= given_d;
      cap_valid_q <= cap_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Kind of the captured verdict.
  always_ff @(posedge clk_i) begin
    if (cap_load) begin
      cap_short_q <= emit_short;
    end
  end

  // Channel lanes.
  tcplc_lane u_lane_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_a_i),
    .accept_i    (in_acc),
    .in_window_i (in_window),
    .clear_i     (end_of_recording_i),
    .capture_i   (cap_load),
    .min_level_i (min_level_q),
    .max_level_i (max_level_q),
    .peak_o      (snap_a),
    .flags_o     (flags_a)
  );

  tcplc_lane u_lane_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_b_i),
    .accept_i    (in_acc),
    .in_window_i (in_window),
    .clear_i     (end_of_recording_i),
    .capture_i   (cap_load),
    .min_level_i (min_level_q),
    .max_level_i (max_level_q),
    .peak_o      (snap_b),
    .flags_o     (flags_b)
  );

  tcplc_lane u_lane_c (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_c_i),
    .accept_i    (in_acc),
    .in_window_i (in_window),
    .clear_i     (end_of_recording_i),
    .capture_i   (cap_load),
    .min_level_i (min_level_q),
    .max_level_i (max_level_q),
    .peak_o      (snap_c),
    .flags_o     (flags_c)
  );

  // Merge the lane results into a verdict.
  tcplc_merge u_merge (
    .flags_a_i      (flags_a),
    .flags_b_i      (flags_b),
    .flags_c_i      (flags_c),
    .peak_a_i       (snap_a),
    .peak_b_i       (snap_b),
    .max_mismatch_i (max_mismatch_q),
    .too_short_i    (cap_short_q),
    .verdict_o      (verdict)
  );

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      verdict_q <= verdict;
      peak_a_q  <= snap_a;
      peak_b_q  <= snap_b;
      peak_c_q  <= snap_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign peak_a_o    = peak_a_q;
  assign peak_b_o    = peak_b_q;
  assign peak_c_o    = peak_c_q;

  // Checks on the recording state and pipeline.
  `TCPLC_NEVER(a_stall_needs_capture, in_stall_o && !cap_valid_q, "stall without a waiting result")
  `TCPLC_ASSERT(a_eor_clears, in_acc && end_of_recording_i |=> ~|frame_idx_q && !given_q, "not cleared")
  `TCPLC_ASSERT(a_win_given, in_acc && emit_win && !end_of_recording_i |=> given_q, "flag not set")
  `TCPLC_NEVER(a_one_verdict, given_q && cap_load, "second verdict in one recording")

endmodule

### rtl/core/tcplc_lane.sv
// One channel lane: running positive peak, captured copy and level compares.
// Depends on tcplc_pkg.
`timescale 1ns / 1ps
module tcplc_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [tcplc_pkg::SampleW-1:0] sample_i,
  input  logic                                 accept_i,
  input  logic                                 in_window_i,
  input  logic                                 clear_i,
  input  logic                                 capture_i,
  input  logic        [tcplc_pkg::PeakW-1:0]   min_level_i,
  input  logic        [tcplc_pkg::PeakW-1:0]   max_level_i,
  output logic        [tcplc_pkg::PeakW-1:0]   peak_o,
  output tcplc_pkg::lane_flags_t               flags_o
);

  logic [tcplc_pkg::PeakW-1:0] peak_q;
  logic [tcplc_pkg::PeakW-1:0] peak_d;
  logic [tcplc_pkg::PeakW-1:0] snap_q;
  logic                        raise;

  // A sample raises the peak only when it is non-negative and larger.
  assign raise  = !sample_i[tcplc_pkg::SampleW-1] &&
                  (sample_i[tcplc_pkg::PeakW-1:0] > peak_q);
  assign peak_d = (in_window_i && raise) ? sample_i[tcplc_pkg::PeakW-1:0] : peak_q;

  // Running peak, cleared at the end of a recording.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else if (accept_i) begin
      peak_q <= clear_i ? '0 : peak_d;
    end
  end

  // Copy of the updated peak for the transaction that reports a verdict.
  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      snap_q <= peak_d;
    end
  end

  assign peak_o            = snap_q;
  assign flags_o.below_min = snap_q < min_level_i;
  assign flags_o.above_max = snap_q > max_level_i;

endmodule

### rtl/core/tcplc_merge.sv
// Merging stage: combines the lane level flags and the channel zero/one
// mismatch into one verdict. Depends on tcplc_pkg.
`timescale 1ns / 1ps
module tcplc_merge (
  input  tcplc_pkg::lane_flags_t             flags_a_i,
  input  tcplc_pkg::lane_flags_t             flags_b_i,
  input  tcplc_pkg::lane_flags_t             flags_c_i,
  input  logic [tcplc_pkg::PeakW-1:0]        peak_a_i,
  input  logic [tcplc_pkg::PeakW-1:0]        peak_b_i,
  input  logic [tcplc_pkg::MismW-1:0]        max_mismatch_i,
  input  logic                               too_short_i,
  output tcplc_pkg::verdict_e                verdict_o
);

  logic [tcplc_pkg::PeakW-1:0] diff;
  logic                        any_low;
  logic                        any_high;
  logic                        mismatch;

  // Absolute difference of the channel zero and channel one peaks.
  assign diff     = (peak_a_i >= peak_b_i) ? (peak_a_i - peak_b_i) : (peak_b_i - peak_a_i);
  assign mismatch = {1'b0, diff} > max_mismatch_i;
  assign any_low  = flags_a_i.below_min || flags_b_i.below_min || flags_c_i.below_min;
  assign any_high = flags_a_i.above_max || flags_b_i.above_max || flags_c_i.above_max;

  // Priority: too short, too quiet, clipping, mismatch, pass.
  always_comb begin
    if (too_short_i) begin
      verdict_o = tcplc_pkg::VERDICT_TOO_SHORT;
    end else if (any_low) begin
      verdict_o = tcplc_pkg::VERDICT_QUIET;
    end else if (any_high) begin
      verdict_o = tcplc_pkg::VERDICT_CLIP;
    end else if (mismatch) begin
      verdict_o = tcplc_pkg::VERDICT_MISMATCH;
    end else begin
      verdict_o = tcplc_pkg::VERDICT_PASS;
    end
  end

endmodule
